// ----- sv/sgr_pkg.sv -----
// shared types, constants and the 5x7 font rom for the glyph row renderer
// no dependencies
package sgr_pkg;

  localparam int unsigned DefScreenWidth  = 240;
  localparam int unsigned DefScreenHeight = 320;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned GlyphCols       = 5;
  localparam int unsigned GlyphRows       = 7;
  localparam int unsigned MaxScale        = 4;
  localparam int unsigned MaxRowPixels    = 24;

  localparam logic [1:0] REG_FG_COLOR = 2'd0;
  localparam logic [1:0] REG_BG_COLOR = 2'd1;
  localparam logic [1:0] REG_MAGNIFY  = 2'd2;

  // column 0 is element 0, each column holds glyph rows 0..6 in bits 0..6
  typedef logic [0:GlyphCols-1][GlyphRows-1:0] glyph_t;

  typedef struct packed {
    logic [GlyphCols-1:0] col_bits;
    logic [2:0]           scale;
    logic [4:0]           width;
  } job_t;

  function automatic glyph_t font_lookup(input logic [7:0] code);
    logic [7:0] folded;
    glyph_t     g;
    folded = code;
    if (code >= "a" && code <= "z") begin
      folded = code - 8'd32;
    end
    case (folded)
      "-":     g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      ".":     g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      ":":     g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      "/":     g = {7'h40, 7'h30, 7'h08, 7'h06, 7'h01};
      "+":     g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
      "%":     g = {7'h63, 7'h13, 7'h08, 7'h64, 7'h63};
      "0":     g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      "1":     g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      "2":     g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      "3":     g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      "4":     g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      "5":     g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      "6":     g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      "7":     g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      "8":     g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      "9":     g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      "A":     g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      "B":     g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      "C":     g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      "D":     g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      "E":     g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      "F":     g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      "G":     g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
      "H":     g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      "I":     g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      "J":     g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      "K":     g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      "L":     g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      "M":     g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      "N":     g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      "O":     g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      "P":     g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      "Q":     g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      "R":     g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      "S":     g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      "T":     g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      "U":     g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      "V":     g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      "W":     g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
      "X":     g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      "Y":     g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      "Z":     g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      "_":     g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- sv/scaled_glyph_row_renderer_top.sv -----
// top level of the scaled glyph row renderer: config registers, front, queue, back
// depends on sgr_pkg, sgr_front, sgr_queue, sgr_back
//
// a command (character code, cell position, wanted cell row) is taken at a clock
// edge where start is high and busy is low. the block emits that row of the
// magnified 6x8 cell as rgb565 pixels, one per cycle, each on the out_ ports
// for a single cycle with out_strobe high; out_row_end marks the last pixel.
// commands whose cell or row is off screen produce no pixels.
// an accepted command passes the front end staging register, the job queue and
// the back end job and output registers before its first pixel. a row has
// 6 x scale pixels (6 to 24), fewer when clipped at the right edge. the front
// end classifies one command a cycle while the queue has room, into a four-deep
// job queue, so busy rises only when that queue is full. the receiver cannot
// stall: every strobed pixel is taken. cfg_we writes fg colour (index 0), bg
// colour (1) or magnify (2); write only while no command is in flight.
// reset (rst_n low, synchronous) empties the queue, drops any row in progress
// and restores white on black at scale 1.
module scaled_glyph_row_renderer_top #(
  parameter int unsigned SCREEN_WIDTH  = sgr_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = sgr_pkg::DefScreenHeight
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_char_code,
  input  logic [9:0]  in_pos_x,
  input  logic [9:0]  in_pos_y,
  input  logic [4:0]  in_cell_row,
  output logic        out_strobe,
  output logic [15:0] out_pixel_color,
  output logic [4:0]  out_cell_col,
  output logic        out_row_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] fg_color_r;
  logic [15:0] bg_color_r;
  logic [7:0]  magnify_r;

  logic          q_full;
  logic          q_push;
  sgr_pkg::job_t q_entry;
  logic          q_pop;
  logic          q_valid;
  sgr_pkg::job_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r <= 16'hFFFF;
      bg_color_r <= 16'h0000;
      magnify_r  <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgr_pkg::REG_FG_COLOR: fg_color_r <= cfg_wdata;
        sgr_pkg::REG_BG_COLOR: bg_color_r <= cfg_wdata;
        sgr_pkg::REG_MAGNIFY:  magnify_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  sgr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_char_code (in_char_code),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_cell_row  (in_cell_row),
    .magnify      (magnify_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  sgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  sgr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .fg_color        (fg_color_r),
    .bg_color        (bg_color_r),
    .out_strobe      (out_strobe),
    .out_pixel_color (out_pixel_color),
    .out_cell_col    (out_cell_col),
    .out_row_end     (out_row_end)
  );

endmodule

// ----- sv/sgr_front.sv -----
// front end: accepts commands, clips the cell and picks the glyph row bits
// depends on sgr_pkg; feeds sgr_queue
module sgr_front #(
  parameter int unsigned SCREEN_WIDTH  = sgr_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = sgr_pkg::DefScreenHeight
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_char_code,
  input  logic [9:0]        in_pos_x,
  input  logic [9:0]        in_pos_y,
  input  logic [4:0]        in_cell_row,
  input  logic [7:0]        magnify,
  input  logic              q_full,
  output logic              q_push,
  output sgr_pkg::job_t     q_entry
);

  localparam logic [10:0] ScrW = 11'(SCREEN_WIDTH);
  localparam logic [10:0] ScrH = 11'(SCREEN_HEIGHT);

  logic       st_valid_r, st_valid_nxt;
  logic [7:0] st_code_r;
  logic [9:0] st_px_r;
  logic [9:0] st_py_r;
  logic [4:0] st_row_r;

  logic [2:0]     scale;
  logic [4:0]     cell_w;
  logic [5:0]     cell_h;
  logic [10:0]    x_end;
  logic [10:0]    y_end;
  logic [10:0]    x_room;
  logic [10:0]    y_room;
  logic [4:0]     width;
  logic [5:0]     height;
  logic [2:0]     src_row;
  logic [9:0]     row_x11;
  logic           keep;
  sgr_pkg::glyph_t glyph;
  logic [sgr_pkg::GlyphCols-1:0] col_bits;

  assign busy = st_valid_r && q_full;

  always_comb begin
    if (magnify == 8'd0) begin
      scale = 3'd1;
    end else if (magnify > 8'(sgr_pkg::MaxScale)) begin
      scale = 3'(sgr_pkg::MaxScale);
    end else begin
      scale = magnify[2:0];
    end
  end

  always_comb begin
    row_x11 = {5'd0, st_row_r} * 10'd11;
    unique case (scale)
      3'd1: begin
        cell_w  = 5'd6;
        cell_h  = 6'd8;
        src_row = st_row_r[2:0];
      end
      3'd2: begin
        cell_w  = 5'd12;
        cell_h  = 6'd16;
        src_row = st_row_r[3:1];
      end
      3'd3: begin
        cell_w  = 5'd18;
        cell_h  = 6'd24;
        src_row = row_x11[7:5];
      end
      default: begin
        cell_w  = 5'd24;
        cell_h  = 6'd32;
        src_row = st_row_r[4:2];
      end
    endcase
  end

  always_comb begin
    x_end  = {1'b0, st_px_r} + {6'd0, cell_w};
    y_end  = {1'b0, st_py_r} + {5'd0, cell_h};
    x_room = ScrW - {1'b0, st_px_r};
    y_room = ScrH - {1'b0, st_py_r};
    width  = (x_end > ScrW) ? x_room[4:0] : cell_w;
    height = (y_end > ScrH) ? y_room[5:0] : cell_h;
    keep   = ({1'b0, st_px_r} < ScrW) && ({1'b0, st_py_r} < ScrH)
             && ({1'b0, st_row_r} < height);
  end

  always_comb begin
    glyph = sgr_pkg::font_lookup(st_code_r);
    for (int c = 0; c < sgr_pkg::GlyphCols; c++) begin
      col_bits[c] = (src_row < 3'(sgr_pkg::GlyphRows)) ? glyph[c][src_row] : 1'b0;
    end
  end

  assign q_push           = st_valid_r && !q_full && keep;
  assign q_entry.col_bits = col_bits;
  assign q_entry.scale    = scale;
  assign q_entry.width    = width;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (start && !busy) begin
      st_valid_nxt = 1'b1;
    end else if (st_valid_r && !q_full) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      st_code_r <= in_char_code;
      st_px_r   <= in_pos_x;
      st_py_r   <= in_pos_y;
      st_row_r  <= in_cell_row;
    end
  end

endmodule

// ----- sv/sgr_queue.sv -----
// small job queue between the front end and the pixel back end
// depends on sgr_pkg
module sgr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sgr_pkg::job_t push_entry,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sgr_pkg::job_t head
);

  localparam int unsigned PtrW = $clog2(sgr_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(sgr_pkg::QueueDepth + 1);

  sgr_pkg::job_t mem_r [sgr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_pop;

  assign full       = (count_r == CntW'(sgr_pkg::QueueDepth));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/sgr_back.sv -----
// back end: walks the scaled row one pixel a cycle and drives the result ports
// depends on sgr_pkg; fed by sgr_queue
module sgr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sgr_pkg::job_t q_head,
  output logic          q_pop,
  input  logic [15:0]   fg_color,
  input  logic [15:0]   bg_color,
  output logic          out_strobe,
  output logic [15:0]   out_pixel_color,
  output logic [4:0]    out_cell_col,
  output logic          out_row_end
);

  logic          act_r, act_nxt;
  sgr_pkg::job_t job_r;
  logic [4:0]    col_r, col_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [2:0]    src_col_r, src_col_nxt;
  logic          last;
  logic [7:0]    bits_ext;
  logic          pix_on;

  logic          strobe_r;
  logic [15:0]   color_r;
  logic [4:0]    ocol_r;
  logic          oend_r;

  assign last     = (col_r == job_r.width - 5'd1);
  assign q_pop    = q_valid && (!act_r || last);
  assign bits_ext = {3'd0, job_r.col_bits};
  assign pix_on   = bits_ext[src_col_r];

  always_comb begin
    act_nxt     = act_r;
    col_nxt     = col_r;
    sub_nxt     = sub_r;
    src_col_nxt = src_col_r;
    if (q_pop) begin
      act_nxt     = 1'b1;
      col_nxt     = '0;
      sub_nxt     = '0;
      src_col_nxt = '0;
    end else if (act_r && last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      col_nxt = col_r + 5'd1;
      if ({1'b0, sub_r} == job_r.scale - 3'd1) begin
        sub_nxt     = '0;
        src_col_nxt = src_col_r + 3'd1;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      strobe_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    sub_r     <= sub_nxt;
    src_col_r <= src_col_nxt;
    if (q_pop) begin
      job_r <= q_head;
    end
    color_r <= pix_on ? fg_color : bg_color;
    ocol_r  <= col_r;
    oend_r  <= last;
  end

  assign out_strobe      = strobe_r;
  assign out_pixel_color = color_r;
  assign out_cell_col    = ocol_r;
  assign out_row_end     = oend_r;

`ifndef SYNTH
  a_row_continues: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !oend_r |=> strobe_r)
    else $error("row broken before its last pixel");

  a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !oend_r |=> ocol_r == $past(ocol_r) + 5'd1)
    else $error("cell column did not advance by one");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ocol_r < 5'(sgr_pkg::MaxRowPixels))
    else $error("cell column beyond widest row");

  a_no_pop_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && !last |-> !q_pop)
    else $error("job taken while a row is still running");
`endif

endmodule

// ----- tb/sgr_row_checker.sv -----
// checker for the scaled glyph row renderer: watches commands, register writes and pixels,
// predicts each row of pixels from its own font table and compares them in order
// depends on sgr_pkg for the register indexes and the default screen size
module sgr_row_checker #(
  parameter int unsigned SCREEN_W = sgr_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_H = sgr_pkg::DefScreenHeight
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_char_code,
  input  logic [9:0]  in_pos_x,
  input  logic [9:0]  in_pos_y,
  input  logic [4:0]  in_cell_row,
  input  logic        out_strobe,
  input  logic [15:0] out_pixel_color,
  input  logic [4:0]  out_cell_col,
  input  logic        out_row_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        quiet,
  output int unsigned error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [0:4][7:0] glyph_cols_t;

  typedef struct packed {
    logic [15:0] colour;
    logic [4:0]  col;
    logic        row_end;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic [15:0] fg_reg;
  logic [15:0] bg_reg;
  logic [7:0]  mag_reg;
  int unsigned errors = 0;

  initial quiet = 1'b0;
  assign error_count = errors;

  function automatic glyph_cols_t glyph_columns(input logic [7:0] code);
    logic [7:0]  c;
    glyph_cols_t g;
    c = code;
    if (code >= "a" && code <= "z") begin
      c = code - 8'h20;
    end
    case (c)
      "-": g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      ".": g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      ":": g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      "/": g = {8'h40, 8'h30, 8'h08, 8'h06, 8'h01};
      "+": g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
      "%": g = {8'h63, 8'h13, 8'h08, 8'h64, 8'h63};
      "0": g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      "1": g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      "2": g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      "3": g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      "4": g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      "5": g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      "6": g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      "7": g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      "8": g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      "9": g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      "A": g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      "B": g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      "C": g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      "D": g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      "E": g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      "F": g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      "G": g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      "H": g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      "I": g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      "J": g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      "K": g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      "L": g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      "M": g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      "N": g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      "O": g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      "P": g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      "Q": g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      "R": g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      "S": g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      "T": g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      "U": g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      "V": g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      "W": g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      "X": g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      "Y": g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      "Z": g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      "_": g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic void predict_row(input logic [7:0] code, input logic [9:0] px,
                                      input logic [9:0] py, input logic [4:0] row);
    int unsigned scale;
    int unsigned width;
    int unsigned height;
    int unsigned src_row;
    int unsigned src_col;
    int unsigned col;
    glyph_cols_t g;
    logic [7:0]  bits;
    pixel_t      p;
    scale = mag_reg;
    if (scale == 0) begin
      scale = 1;
    end
    if (scale > 4) begin
      scale = 4;
    end
    if (px >= SCREEN_W || py >= SCREEN_H) begin
      return;
    end
    width  = 6 * scale;
    height = 8 * scale;
    if (px + width > SCREEN_W) begin
      width = SCREEN_W - px;
    end
    if (py + height > SCREEN_H) begin
      height = SCREEN_H - py;
    end
    if (row >= height) begin
      return;
    end
    g       = glyph_columns(code);
    src_row = row / scale;
    for (col = 0; col < width; col++) begin
      src_col   = col / scale;
      // spacing column and glyph row 7 stay background
      bits      = (src_col < 5) ? (g[src_col] & 8'h7F) : 8'h00;
      p.colour  = bits[src_row] ? fg_reg : bg_reg;
      p.col     = col[4:0];
      p.row_end = (col + 1 == width);
      pixel_q.push_back(p);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      fg_reg  = 16'hFFFF;
      bg_reg  = 16'h0000;
      mag_reg = 8'd1;
      pixel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgr_pkg::REG_FG_COLOR: fg_reg  = cfg_wdata;
          sgr_pkg::REG_BG_COLOR: bg_reg  = cfg_wdata;
          sgr_pkg::REG_MAGNIFY:  mag_reg = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_row(in_char_code, in_pos_x, in_pos_y, in_cell_row);
      end
      if (out_strobe) begin
        got = {out_pixel_color, out_cell_col, out_row_end};
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t unexpected pixel: colour %h col %0d end %b",
                   $time, got.colour, got.col, got.row_end);
        end else begin
          want = pixel_q.pop_front();
          if (got.colour !== want.colour || got.col !== want.col ||
              got.row_end !== want.row_end) begin
            errors++;
            $display("%0t pixel error: expected colour %h col %0d end %b, got colour %h col %0d end %b",
                     $time, want.colour, want.col, want.row_end,
                     got.colour, got.col, got.row_end);
          end
        end
      end
    end
    quiet <= (pixel_q.size() == 0);
  end

endmodule

// ----- tb/scaled_glyph_row_renderer_top_test.sv -----
// testbench top for the scaled glyph row renderer: clock, reset, register writes and
// bursty command stimulus, directed then random, with the verdict at the end
// depends on sgr_pkg, scaled_glyph_row_renderer_top and sgr_row_checker
module scaled_glyph_row_renderer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ScreenW     = sgr_pkg::DefScreenWidth;
  localparam int unsigned ScreenH     = sgr_pkg::DefScreenHeight;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 48;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_char_code = '0;
  logic [9:0]  in_pos_x = '0;
  logic [9:0]  in_pos_y = '0;
  logic [4:0]  in_cell_row = '0;
  logic        out_strobe;
  logic [15:0] out_pixel_color;
  logic [4:0]  out_cell_col;
  logic        out_row_end;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = sgr_pkg::REG_FG_COLOR;
  logic [15:0] cfg_wdata = '0;
  logic        quiet;
  int unsigned error_count;

  int unsigned burst_left = 0;
  int unsigned stall_cycles = 0;
  logic [7:0]  cur_mag = 8'd1;
  string       glyph_set = " -.:/+%0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz";

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  scaled_glyph_row_renderer_top #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_cell_row    (in_cell_row),
    .out_strobe     (out_strobe),
    .out_pixel_color(out_pixel_color),
    .out_cell_col   (out_cell_col),
    .out_row_end    (out_row_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  sgr_row_checker #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_cell_row    (in_cell_row),
    .out_strobe     (out_strobe),
    .out_pixel_color(out_pixel_color),
    .out_cell_col   (out_cell_col),
    .out_row_end    (out_row_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .quiet          (quiet),
    .error_count    (error_count)
  );

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int unsigned eff_scale();
    if (cur_mag == 0) begin
      return 1;
    end
    if (cur_mag > 4) begin
      return 4;
    end
    return {24'd0, cur_mag};
  endfunction

  task automatic issue(input logic [7:0] code, input logic [9:0] px, input logic [9:0] py,
                       input logic [4:0] row);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start        <= 1'b1;
    in_char_code <= code;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_cell_row  <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (!quiet) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] fg, input logic [15:0] bg,
                           input logic [15:0] mag);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= sgr_pkg::REG_FG_COLOR;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_index <= sgr_pkg::REG_BG_COLOR;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_index <= sgr_pkg::REG_MAGNIFY;
    cfg_wdata <= mag;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_mag    = mag[7:0];
    burst_left = 0;
  endtask

  task automatic random_item(output bit shaped);
    int unsigned s;
    logic [7:0]  code;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [4:0]  row;
    s = eff_scale();
    if ($urandom_range(0, 4) == 0) begin
      code   = 8'($urandom);
      px     = 10'($urandom);
      py     = 10'($urandom);
      row    = 5'($urandom);
      shaped = 1'b0;
    end else begin
      code = glyph_set[$urandom_range(0, glyph_set.len() - 1)];
      if ($urandom_range(0, 9) == 0) begin
        code = 8'($urandom);
      end
      // edge cells often, to exercise the clipping
      px     = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(ScreenW - 6 * s, ScreenW - 1))
                                           : 10'($urandom_range(0, ScreenW - 1));
      py     = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(ScreenH - 8 * s, ScreenH - 1))
                                           : 10'($urandom_range(0, ScreenH - 1));
      row    = 5'($urandom_range(0, 8 * s - 1));
      shaped = 1'b1;
    end
    issue(code, px, py, row);
  endtask

  initial begin
    int unsigned done;
    bit          shaped;
    logic [7:0]  mag;
    logic [15:0] fg;
    logic [15:0] bg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset colours and scale
    issue("A", 10'd0, 10'd0, 5'd0);
    issue("Z", 10'd234, 10'd0, 5'd3);
    issue("a", 10'd10, 10'd10, 5'd2);
    issue("z", 10'd20, 10'd10, 5'd6);
    issue(8'h80, 10'd0, 10'd0, 5'd1);
    issue(8'hFF, 10'd30, 10'd0, 5'd2);
    issue(8'h00, 10'd40, 10'd0, 5'd0);
    issue("?", 10'd50, 10'd0, 5'd3);
    issue("B", 10'd0, 10'd0, 5'd7);
    issue("%", 10'd0, 10'd0, 5'd4);
    issue("_", 10'd60, 10'd0, 5'd6);
    issue("8", 10'd239, 10'd0, 5'd3);
    issue("M", 10'd236, 10'd5, 5'd2);
    issue("H", 10'd240, 10'd0, 5'd0);
    issue("H", 10'd1023, 10'd1023, 5'd31);
    issue("H", 10'd0, 10'd320, 5'd0);
    issue("W", 10'd0, 10'd319, 5'd0);
    issue("W", 10'd0, 10'd319, 5'd1);
    issue("K", 10'd0, 10'd313, 5'd6);
    issue("K", 10'd100, 10'd100, 5'd8);
    issue("Q", 10'd100, 10'd100, 5'd31);
    issue("9", 10'd233, 10'd312, 5'd7);

    for (int phase = 0; phase < 8; phase++) begin
      fg = 16'($urandom);
      bg = 16'($urandom);
      case (phase)
        0: begin
          mag = 8'd0;
          fg  = 16'h0000;
          bg  = 16'hFFFF;
        end
        1: mag = 8'd4;
        2: mag = 8'd255;
        3: mag = 8'd2;
        4: mag = 8'd3;
        5: mag = 8'd1;
        6: mag = 8'($urandom_range(5, 254));
        default: mag = 8'($urandom);
      endcase
      configure(fg, bg, {8'($urandom), mag});
      done = 0;
      while (done < PhaseItems) begin
        random_item(shaped);
        if (shaped) begin
          done++;
        end
      end
    end

    settle();
    if (error_count == 0 && quiet) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sgr_pkg.sv
sv/sgr_front.sv
sv/sgr_queue.sv
sv/sgr_back.sv
sv/scaled_glyph_row_renderer_top.sv
tb/sgr_row_checker.sv
tb/scaled_glyph_row_renderer_top_test.sv
